// ===== hdl/i2cbb_pkg.sv =====
// Shared types and constants for the I2C bit-bang master sequencer.
// No dependencies; imported by i2cbb_step and the top level.
package i2cbb_pkg;

    localparam int CMD_W   = 3;
    localparam int PHASE_W = 5;
    localparam int BYTE_W  = 8;

    // Last phase index of the multi-phase commands
    localparam logic [PHASE_W-1:0] SEND_LAST_PHASE = 5'd23;
    localparam logic [PHASE_W-1:0] RECV_LAST_PHASE = 5'd16;

    // Scale for the divide-by-three of the send phase: (p * 11) >> 5 for p < 24
    localparam logic [3:0] DIV3_MUL   = 4'd11;
    localparam int         DIV3_SHIFT = 5;

    typedef enum logic [CMD_W-1:0] {
        OP_IDLE  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_SEND  = 3'd3,
        OP_RECV  = 3'd4,
        OP_SACK  = 3'd5,
        OP_RACK  = 3'd6
    } op_t;

    // Sequencer state carried from word to word
    typedef struct packed {
        op_t                 op;
        logic [PHASE_W-1:0]  phase;
        logic [BYTE_W-1:0]   shift;
        logic                scl;
        logic                sda;
        logic                ack_seen;
        logic [BYTE_W-1:0]   rx_hold;
    } seq_state_t;

    // One result word
    typedef struct packed {
        logic                scl;
        logic                sda_release;
        logic                busy;
        logic                done;
        logic [BYTE_W-1:0]   rx_byte;
        logic                rx_ack;
    } seq_result_t;

endpackage

// ===== hdl/i2cbb_step.sv =====
// Combinational phase step: takes the current sequencer state and one input
// word, gives the next state and the result word. Depends on i2cbb_pkg.
module i2cbb_step (
    input  i2cbb_pkg::seq_state_t   state_cur,
    input  logic [2:0]              cmd,
    input  logic [7:0]              data_byte,
    input  logic                    ack_bit,
    input  logic                    sda_in,
    output i2cbb_pkg::seq_state_t   state_nxt,
    output i2cbb_pkg::seq_result_t  result
);
    import i2cbb_pkg::*;

    seq_state_t          st;
    logic                take_cmd;
    logic                busy;
    logic                last;
    logic [PHASE_W-1:0]  p;
    logic [8:0]          div3_prod;
    logic [2:0]          send_bit;
    logic [1:0]          send_sub;
    logic [PHASE_W-1:0]  q;
    logic [2:0]          recv_bit;

    // Decode the send phase into bit number and sub-phase
    assign p         = take_cmd ? '0 : state_cur.phase;
    assign div3_prod = {4'd0, p} * {5'd0, DIV3_MUL};
    assign send_bit  = div3_prod[DIV3_SHIFT +: 3];
    assign send_sub  = 2'(p - PHASE_W'({send_bit, 1'b0} + {2'd0, send_bit}));
    assign q         = p - PHASE_W'(1);
    assign recv_bit  = q[3:1];

    // Idle state takes any valid command code
    assign take_cmd = (state_cur.op == OP_IDLE)
                   && (cmd >= CMD_W'(OP_START)) && (cmd <= CMD_W'(OP_RACK));

    always_comb begin
        st   = state_cur;
        busy = 1'b0;
        last = 1'b0;

        // Latch a new command
        if (take_cmd) begin
            st.op    = op_t'(cmd);
            st.phase = '0;
            if (op_t'(cmd) == OP_SEND) st.shift = data_byte;
            if (op_t'(cmd) == OP_RECV) st.shift = '0;
        end

        // Apply one phase of the running command
        if (st.op != OP_IDLE) begin
            busy = 1'b1;
            case (st.op)
                OP_START: begin
                    if (p == 5'd0)      st.sda = 1'b1;
                    else if (p == 5'd1) st.scl = 1'b1;
                    else if (p == 5'd2) st.sda = 1'b0;
                    else begin
                        st.scl = 1'b0;
                        last   = 1'b1;
                    end
                end
                OP_STOP: begin
                    if (p == 5'd0)      st.sda = 1'b0;
                    else if (p == 5'd1) st.scl = 1'b1;
                    else begin
                        st.sda = 1'b1;
                        last   = 1'b1;
                    end
                end
                OP_SEND: begin
                    if (send_sub == 2'd0)      st.sda = st.shift[3'd7 - send_bit];
                    else if (send_sub == 2'd1) st.scl = 1'b1;
                    else begin
                        st.scl = 1'b0;
                        if (p >= SEND_LAST_PHASE) last = 1'b1;
                    end
                end
                OP_RECV: begin
                    if (p == 5'd0) begin
                        st.sda = 1'b1;
                    end else if (!q[0]) begin
                        st.scl = 1'b1;
                        if (sda_in) st.shift[3'd7 - recv_bit] = 1'b1;
                    end else begin
                        st.scl = 1'b0;
                        if (p >= RECV_LAST_PHASE) begin
                            st.rx_hold = st.shift;
                            last       = 1'b1;
                        end
                    end
                end
                OP_SACK: begin
                    if (p == 5'd0)      st.sda = ack_bit;
                    else if (p == 5'd1) st.scl = 1'b1;
                    else begin
                        st.scl = 1'b0;
                        last   = 1'b1;
                    end
                end
                OP_RACK: begin
                    if (p == 5'd0) begin
                        st.sda = 1'b1;
                    end else if (p == 5'd1) begin
                        st.scl      = 1'b1;
                        st.ack_seen = sda_in;
                    end else begin
                        st.scl = 1'b0;
                        last   = 1'b1;
                    end
                end
                default: begin
                    last = 1'b1;
                end
            endcase

            // Advance or drop back to idle
            if (last) begin
                st.op    = OP_IDLE;
                st.phase = '0;
            end else begin
                st.phase = p + PHASE_W'(1);
            end
        end
    end

    assign state_nxt          = st;
    assign result.scl         = st.scl;
    assign result.sda_release = st.sda;
    assign result.busy        = busy;
    assign result.done        = last;
    assign result.rx_byte     = st.rx_hold;
    assign result.rx_ack      = st.ack_seen;

endmodule

// ===== hdl/i2c_bitbang_master_sequencer.sv =====
// Top level of the I2C bit-bang master sequencer: input register, state and
// result register around i2cbb_step. Depends on i2cbb_pkg and i2cbb_step.
//
//   channel | direction | ports                                    | handshake
//   --------+-----------+------------------------------------------+-----------------
//   s_      | in        | cmd, data_byte, ack_bit, sda_in          | s_valid/s_ready
//   m_      | out       | scl, sda_release, busy_res, done_res,    | m_valid/m_ready
//           |           | rx_byte, rx_ack                          |
//
// One word per cycle sustained while m_ready is high; a word is registered in
// the input register and then in the result register. The phase step is a
// single pass of logic from the input register and the state registers into
// the result register. Reset returns the sequencer to idle with both lines
// released and empties both registers. A stall on m_ready holds the result;
// the input register still takes one more word before s_ready drops.
module i2c_bitbang_master_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_cmd,
    input  logic [7:0]  s_data_byte,
    input  logic        s_ack_bit,
    input  logic        s_sda_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_scl,
    output logic        m_sda_release,
    output logic        m_busy_res,
    output logic        m_done_res,
    output logic [7:0]  m_rx_byte,
    output logic        m_rx_ack
);
    import i2cbb_pkg::*;

    logic          in_valid_reg;
    logic [2:0]    cmd_reg;
    logic [7:0]    data_byte_reg;
    logic          ack_bit_reg;
    logic          sda_in_reg;
    seq_state_t    state_reg;
    seq_state_t    state_next;
    seq_result_t   result_next;
    seq_result_t   result_reg;
    logic          out_valid_reg;
    logic          advance;

    // Step when a word waits and the result register is free or draining
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    i2cbb_step u_step (
        .state_cur (state_reg),
        .cmd       (cmd_reg),
        .data_byte (data_byte_reg),
        .ack_bit   (ack_bit_reg),
        .sda_in    (sda_in_reg),
        .state_nxt (state_next),
        .result    (result_next)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg       <= s_cmd;
            data_byte_reg <= s_data_byte;
            ack_bit_reg   <= s_ack_bit;
            sda_in_reg    <= s_sda_in;
        end
    end

    // Sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.op       <= OP_IDLE;
            state_reg.phase    <= '0;
            state_reg.shift    <= '0;
            state_reg.scl      <= 1'b1;
            state_reg.sda      <= 1'b1;
            state_reg.ack_seen <= 1'b1;
            state_reg.rx_hold  <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_scl         = result_reg.scl;
    assign m_sda_release = result_reg.sda_release;
    assign m_busy_res    = result_reg.busy;
    assign m_done_res    = result_reg.done;
    assign m_rx_byte     = result_reg.rx_byte;
    assign m_rx_ack      = result_reg.rx_ack;

endmodule
